FILE: src/u8v_pkg.sv
// Package of the UTF-8 stream validator: widths and byte-class constants.
package u8v_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned CpW   = 21;

  // Continuation bytes still expected; also the length code of a sequence.
  typedef logic [1:0] pend_t;
  typedef logic [CpW-1:0] cp_t;

  localparam logic [DataW-1:0] AsciiMax  = 8'h7f;
  localparam logic [DataW-1:0] Lead2Min  = 8'hc2;
  localparam logic [DataW-1:0] Lead2Max  = 8'hdf;
  localparam logic [DataW-1:0] Lead3Min  = 8'he0;
  localparam logic [DataW-1:0] Lead3Max  = 8'hef;
  localparam logic [DataW-1:0] Lead4Min  = 8'hf0;
  localparam logic [DataW-1:0] Lead4Max  = 8'hf4;
  localparam logic [1:0]       ContTag   = 2'b10;

  localparam pend_t SeqLen2 = 2'd1;
  localparam pend_t SeqLen3 = 2'd2;
  localparam pend_t SeqLen4 = 2'd3;

  localparam cp_t Min3Byte   = 21'h000800;
  localparam cp_t Min4Byte   = 21'h010000;
  localparam cp_t MaxCp      = 21'h10ffff;
  localparam cp_t SurrLo     = 21'h00d800;
  localparam cp_t SurrHi     = 21'h00dfff;

endpackage

FILE: src/u8v_if.sv
// Channel interfaces of the UTF-8 stream validator: byte beats in, verdict beats out.
interface u8v_in_if;
  import u8v_pkg::*;

  logic             valid;
  logic             ready;
  logic [DataW-1:0] data_byte;
  logic             last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8v_out_if;
  logic valid;
  logic ready;
  logic string_valid;

  modport source (output valid, output string_valid, input ready);
  modport sink   (input valid, input string_valid, output ready);
endinterface

FILE: src/utf8_stream_validator_top.sv
// Top level of the UTF-8 stream validator.
// Checks a byte string for strict UTF-8 at one byte per clock: a byte beat is
// taken in every cycle in which the verdict register is empty or being
// drained, and the beat that carries last_byte loads a verdict (1 = valid)
// that appears on the output channel in the next cycle. The sequence tracker
// registers (pending count, sequence length, code point, error flag) update
// in the same cycle as the byte is taken, so there is no bubble between
// strings; a stalled output only holds off input while a verdict waits.
module utf8_stream_validator_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  u8v_in_if.sink        in_i,
  u8v_out_if.source     out_o
);
  import u8v_pkg::*;

  pend_t pend_q, pend_d;
  pend_t len_q, len_d;
  cp_t   cp_q, cp_d;
  logic  err_q, err_d;
  logic  out_valid_q, out_valid_d;
  logic  verdict_q, verdict_d;

  logic       in_acc;
  logic [7:0] b;
  cp_t        cp_cont;
  pend_t      pend_cont;
  logic       cp_bad;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;

  assign cp_cont   = {cp_q[CpW-7:0], b[5:0]};
  assign pend_cont = pend_q - 2'd1;
  assign cp_bad    = ((len_q == SeqLen3) && (cp_cont < Min3Byte))
                  || ((len_q == SeqLen4) && (cp_cont < Min4Byte))
                  || (cp_cont > MaxCp)
                  || ((cp_cont >= SurrLo) && (cp_cont <= SurrHi));

  always_comb begin
    pend_d = pend_q;
    len_d  = len_q;
    cp_d   = cp_q;
    err_d  = err_q;
    if (!err_q) begin
      if (pend_q == 2'd0) begin
        priority if (b == 8'h00) begin
          err_d = 1'b1;
        end else if (b <= AsciiMax) begin
          err_d = 1'b0;
        end else if (b >= Lead2Min && b <= Lead2Max) begin
          len_d  = SeqLen2;
          pend_d = SeqLen2;
          cp_d   = cp_t'(b[4:0]);
        end else if (b >= Lead3Min && b <= Lead3Max) begin
          len_d  = SeqLen3;
          pend_d = SeqLen3;
          cp_d   = cp_t'(b[3:0]);
        end else if (b >= Lead4Min && b <= Lead4Max) begin
          len_d  = SeqLen4;
          pend_d = SeqLen4;
          cp_d   = cp_t'(b[2:0]);
        end else begin
          err_d = 1'b1;
        end
      end else if (b[7:6] != ContTag) begin
        err_d = 1'b1;
      end else begin
        cp_d   = cp_cont;
        pend_d = pend_cont;
        if (pend_cont == 2'd0 && cp_bad) begin
          err_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    verdict_d   = verdict_q;
    if (in_acc && in_i.last_byte) begin
      out_valid_d = 1'b1;
      verdict_d   = !err_d && (pend_d == 2'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      len_q       <= '0;
      cp_q        <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        if (in_i.last_byte) begin
          pend_q <= '0;
          len_q  <= '0;
          cp_q   <= '0;
          err_q  <= 1'b0;
        end else begin
          pend_q <= pend_d;
          len_q  <= len_d;
          cp_q   <= cp_d;
          err_q  <= err_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.string_valid = verdict_q;

endmodule

FILE: src/u8v_checker.sv
// Port-level assertions of the UTF-8 stream validator and their bind.
module u8v_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [7:0] data_byte_i,
  input logic       last_byte_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       string_valid_i
);
  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // stalled verdict beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(string_valid_i))
    else $error("verdict beat dropped or changed while stalled");

  // last byte taken gives a verdict next cycle
  a_last_gives_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_byte_i |=> out_valid_i)
    else $error("no verdict after final byte");

  // every new verdict beat comes from a final byte
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !$past(out_valid_i && !out_ready_i) |-> $past(in_acc && last_byte_i))
    else $error("verdict without final byte");

  // NUL or 11xxxxxx as final byte can never end a valid string
  a_bad_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_byte_i && (data_byte_i == 8'h00 || data_byte_i[7:6] == 2'b11)
    |=> out_valid_i && !string_valid_i)
    else $error("string with invalid final byte passed");

endmodule

bind utf8_stream_validator_top u8v_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .data_byte_i    (in_i.data_byte),
  .last_byte_i    (in_i.last_byte),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .string_valid_i (out_o.string_valid)
);

FILE: dv/tb_utf8_stream_validator_top.sv
// Testbench of the UTF-8 stream validator: directed and random byte strings, verdicts checked.
`timescale 1ns / 1ps

module tb_utf8_stream_validator_top;
  import u8v_pkg::*;

  localparam int unsigned RandBeats  = 600;
  localparam int unsigned CalmBeats  = 100;
  localparam int unsigned HoldAt     = 250;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 8;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic             last;
    logic             typed;
    logic             verdict;
  } beat_t;

  typedef enum int unsigned {StrClean, StrNoise, StrWide, StrFlip, StrCut} str_kind_e;

  // typed verdict only where it is obvious; otherwise the tracker decides
  localparam beat_t DirRows [27] = '{
    '{8'h41, 1'b1, 1'b1, 1'b1},
    '{8'h00, 1'b1, 1'b1, 1'b0},
    '{8'hff, 1'b1, 1'b1, 1'b0},
    '{8'hc1, 1'b1, 1'b1, 1'b0},
    '{8'hf5, 1'b1, 1'b1, 1'b0},
    '{8'hc2, 1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b1, 1'b1, 1'b1},
    '{8'he0, 1'b0, 1'b0, 1'b0},
    '{8'h9f, 1'b0, 1'b0, 1'b0},
    '{8'hbf, 1'b1, 1'b1, 1'b0},
    '{8'hed, 1'b0, 1'b0, 1'b0},
    '{8'ha0, 1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b1, 1'b0, 1'b0},
    '{8'hf4, 1'b0, 1'b0, 1'b0},
    '{8'h8f, 1'b0, 1'b0, 1'b0},
    '{8'hbf, 1'b0, 1'b0, 1'b0},
    '{8'hbf, 1'b1, 1'b0, 1'b0},
    '{8'hf4, 1'b0, 1'b0, 1'b0},
    '{8'h90, 1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b1, 1'b1, 1'b0},
    '{8'he1, 1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b1, 1'b1, 1'b0},
    '{8'hc2, 1'b0, 1'b0, 1'b0},
    '{8'h41, 1'b0, 1'b0, 1'b0},
    '{8'he2, 1'b0, 1'b0, 1'b0},
    '{8'h7f, 1'b1, 1'b1, 1'b0}
  };

  logic clk_i;
  logic rst_ni;

  u8v_in_if  in_if ();
  u8v_out_if out_if ();

  utf8_stream_validator_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  beat_t            byte_plan [$];
  logic [DataW-1:0] str_buf [$];
  bit               verdicts_due [$];
  int unsigned      errors;
  int unsigned      n_verdicts;
  int unsigned      n_valid;
  bit               calm;
  bit               hold_req;
  bit               hold_done;

  pend_t trk_pend;
  pend_t trk_len;
  cp_t   trk_cp;
  bit    trk_err;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic void track_byte(input logic [DataW-1:0] b, input logic fin,
                                     output bit ok);
    if (!trk_err) begin
      if (trk_pend == '0) begin
        if (b == '0) begin
          trk_err = 1'b1;
        end else if (b <= AsciiMax) begin
        end else if (b >= Lead2Min && b <= Lead2Max) begin
          trk_len  = SeqLen2;
          trk_pend = SeqLen2;
          trk_cp   = cp_t'(b[4:0]);
        end else if (b >= Lead3Min && b <= Lead3Max) begin
          trk_len  = SeqLen3;
          trk_pend = SeqLen3;
          trk_cp   = cp_t'(b[3:0]);
        end else if (b >= Lead4Min && b <= Lead4Max) begin
          trk_len  = SeqLen4;
          trk_pend = SeqLen4;
          trk_cp   = cp_t'(b[2:0]);
        end else begin
          trk_err = 1'b1;
        end
      end else if (b[7:6] != ContTag) begin
        trk_err = 1'b1;
      end else begin
        trk_cp   = {trk_cp[CpW-7:0], b[5:0]};
        trk_pend = trk_pend - 2'd1;
        if (trk_pend == '0 &&
            ((trk_len == SeqLen3 && trk_cp < Min3Byte) ||
             (trk_len == SeqLen4 && trk_cp < Min4Byte) ||
             trk_cp > MaxCp || (trk_cp >= SurrLo && trk_cp <= SurrHi))) begin
          trk_err = 1'b1;
        end
      end
    end
    ok = !trk_err && trk_pend == '0;
    if (fin) begin
      trk_pend = '0;
      trk_len  = '0;
      trk_cp   = '0;
      trk_err  = 1'b0;
    end
  endfunction

  function automatic void put_byte(input logic [DataW-1:0] v);
    str_buf.insert(str_buf.size(), v);
  endfunction

  function automatic void push_cp(input cp_t cp, input int unsigned n);
    case (n)
      1: put_byte({1'b0, cp[6:0]});
      2: begin
        put_byte({3'b110, cp[10:6]});
        put_byte({ContTag, cp[5:0]});
      end
      3: begin
        put_byte({4'b1110, cp[15:12]});
        put_byte({ContTag, cp[11:6]});
        put_byte({ContTag, cp[5:0]});
      end
      default: begin
        put_byte({5'b11110, cp[20:18]});
        put_byte({ContTag, cp[17:12]});
        put_byte({ContTag, cp[11:6]});
        put_byte({ContTag, cp[5:0]});
      end
    endcase
  endfunction

  function automatic void add_string();
    int unsigned r;
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    str_kind_e   kind;
    cp_t         cp;
    beat_t       row;
    r = $urandom_range(0, 9);
    kind = (r == 0) ? StrNoise : (r == 1) ? StrWide : (r == 2) ? StrFlip :
           (r == 3) ? StrCut : StrClean;
    str_buf.delete();
    if (kind == StrNoise) begin
      repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        n = $urandom_range(1, 4);
        case (n)
          1:       begin lo = 'h1;     hi = 'h7f;     end
          2:       begin lo = 'h80;    hi = 'h7ff;    end
          3:       begin lo = 'h800;   hi = 'hffff;   end
          default: begin lo = 'h10000; hi = 'h10ffff; end
        endcase
        cp = cp_t'($urandom_range(hi, lo));
        if ($urandom_range(0, 7) == 0) cp = cp_t'($urandom_range(0, 1) ? hi : lo);
        // wide: raw bits, so overlong forms, surrogates and out-of-range points show up
        if (kind == StrWide) cp = cp_t'($urandom_range(0, 'h1fffff));
        push_cp(cp, n);
      end
      if (kind == StrFlip) str_buf[$urandom_range(0, str_buf.size() - 1)] =
                             8'($urandom_range(0, 255));
      if (kind == StrCut && str_buf.size() > 1) void'(str_buf.pop_back());
    end
    foreach (str_buf[i]) begin
      row = '{str_buf[i], i == str_buf.size() - 1, 1'b0, 1'b0};
      byte_plan.insert(byte_plan.size(), row);
    end
  endfunction

  initial begin : drive_bytes
    beat_t bt;
    bit    ok;
    errors    = 0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    trk_pend  = '0;
    trk_len   = '0;
    trk_cp    = '0;
    trk_err   = 1'b0;
    in_if.valid     <= 1'b0;
    in_if.data_byte <= '0;
    in_if.last_byte <= 1'b0;
    foreach (DirRows[i]) byte_plan.insert(byte_plan.size(), DirRows[i]);
    while (byte_plan.size() < $size(DirRows) + RandBeats) add_string();
    @(posedge rst_ni);
    @(posedge clk_i);
    for (int i = 0; i < byte_plan.size(); i++) begin
      bt = byte_plan[i];
      if (i + CalmBeats >= byte_plan.size()) calm = 1'b1;
      if (i == HoldAt) hold_req = 1'b1;
      if (!calm && $urandom_range(0, 4) == 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      in_if.valid     <= 1'b1;
      in_if.data_byte <= bt.data;
      in_if.last_byte <= bt.last;
      do @(posedge clk_i); while (!in_if.ready);
      track_byte(bt.data, bt.last, ok);
      if (bt.last) verdicts_due.insert(verdicts_due.size(), bt.typed ? bt.verdict : ok);
    end
    in_if.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    $display("%0d byte beats (%0d directed), %0d verdicts: %0d valid, %0d invalid",
             byte_plan.size(), $size(DirRows), n_verdicts, n_valid, n_verdicts - n_valid);
    $display("output held off %0d cycles once; random stalls on both sides", HoldCycles);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : drain_verdicts
    int unsigned n;
    hold_done = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_if.ready <= 1'b0;
        n = HoldCycles;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        n = $urandom_range(1, 17);
      end else begin
        out_if.ready <= 1'b1;
        n = $urandom_range(1, 20);
      end
      repeat (n) @(posedge clk_i);
    end
  end

  initial begin
    n_verdicts = 0;
    n_valid    = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (verdicts_due.size() == 0) begin
        $error("string_valid: expected none, got %0b", out_if.string_valid);
        errors++;
      end else begin
        if (out_if.string_valid !== verdicts_due[0]) begin
          $error("string_valid: expected %0b, got %0b", verdicts_due[0], out_if.string_valid);
          errors++;
        end
        void'(verdicts_due.pop_front());
      end
      n_verdicts++;
      if (out_if.string_valid === 1'b1) n_valid++;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", CycleLimit);
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
src/u8v_pkg.sv
src/u8v_if.sv
src/utf8_stream_validator_top.sv
src/u8v_checker.sv
dv/tb_utf8_stream_validator_top.sv
